[hw/rtl/assert_macros.svh]
// Assertion macros shared by the serial servo slew controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define SSC_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ssc assertion failed");
// Condition must never be true outside reset.
`define SSC_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ssc forbidden condition seen");
`else
`define SSC_ASSERT(name, clk, rstn, prop)
`define SSC_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

[hw/rtl/ssc_pkg.sv]
// Types and constants of the serial servo slew controller.
`default_nettype none
package ssc_pkg;

  localparam int CHANNELS   = 6;
  localparam int LINE_LIMIT = 40;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int FC_W       = $clog2(CHANNELS + 1);
  localparam int LEN_W      = $clog2(LINE_LIMIT + 1);
  localparam int ANGLE_W    = 8;
  localparam int VAL_W      = 10;
  localparam int PULSE_W    = 12;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_MID = 8'd90;
  localparam logic [VAL_W-1:0]   FIELD_SAT = 10'd1023;

  // Division by 180 as multiplication by a rounded-up reciprocal; exact below 2^20.
  localparam int              DIV_SHIFT = 28;
  localparam logic [20:0]     DIV_RECIP = 21'd1491309;

  // Character codes.
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Request kinds and result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic RES_PULSE = 1'b0;
  localparam logic RES_ACK   = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_STEP_SIZE   = 3'd0,
    REG_RAMP_PERIOD = 3'd1,
    REG_PULSE_MIN   = 3'd2,
    REG_PULSE_MAX   = 3'd3,
    REG_GRIPPER     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_MUL, ST_DIV, ST_EMIT
  } state_e;

  typedef struct packed {
    logic [3:0]  step_size;
    logic [7:0]  ramp_period;
    logic [11:0] pulse_min;
    logic [11:0] pulse_max;
    logic [7:0]  gripper_limit;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic mul;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic ramp_due;
    logic last_ch;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/serial_servo_slew_controller_core.sv]
// Top level of the serial servo slew controller: register port and module wiring.
//
// Requests arrive on the in channel (in_valid_i, in_stall_o): kind_i 0 carries a
// received character in rx_byte_i, kind_i 1 a one millisecond tick. Characters
// build a comma-separated line of angles that is committed on newline; a line of
// six values answers with an acknowledge result. Every ramp_period ticks each
// channel steps toward its target and a pulse width result is given per channel.
// Results leave on the out channel (out_valid_o, out_stall_i) through one output
// register. A character request is handled when it is accepted; an acknowledge is valid in the
// cycle after it. A tick that triggers an update walks each channel in turn through
// step, multiply, divide by reciprocal and emit; the next request can be taken
// once the last channel is emitted and nothing stalls. Other ticks only advance the
// tick counter. Requests are taken only while no ramp walk runs and the output
// register is free. While the receiver stalls, the output register holds its
// result and the block waits. Reset restores the register defaults, centres all
// channels except the last, which goes to 0, and clears the line parser; no
// pulses are sent at reset.
`default_nettype none
module serial_servo_slew_controller_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire          kind_i,
  input  wire  [7:0]   rx_byte_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic         result_kind_o,
  output logic [2:0]   channel_o,
  output logic [11:0]  pulse_us_o,
  output logic         last_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [4:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ssc_pkg::cfg_t    cfg_q;
  ssc_pkg::cmd_t    cmd;
  ssc_pkg::status_t status;
  ssc_pkg::reg_idx_e reg_idx;
  logic             cfg_we;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = ssc_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= 4'd3;
      cfg_q.ramp_period   <= 8'd8;
      cfg_q.pulse_min     <= 12'd500;
      cfg_q.pulse_max     <= 12'd2500;
      cfg_q.gripper_limit <= 8'd60;
    end else if (cfg_we) begin
      unique case (reg_idx)
        ssc_pkg::REG_STEP_SIZE:   cfg_q.step_size     <= pwdata[3:0];
        ssc_pkg::REG_RAMP_PERIOD: cfg_q.ramp_period   <= pwdata[7:0];
        ssc_pkg::REG_PULSE_MIN:   cfg_q.pulse_min     <= pwdata[11:0];
        ssc_pkg::REG_PULSE_MAX:   cfg_q.pulse_max     <= pwdata[11:0];
        ssc_pkg::REG_GRIPPER:     cfg_q.gripper_limit <= pwdata[7:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      ssc_pkg::REG_STEP_SIZE:   prdata = {28'd0, cfg_q.step_size};
      ssc_pkg::REG_RAMP_PERIOD: prdata = {24'd0, cfg_q.ramp_period};
      ssc_pkg::REG_PULSE_MIN:   prdata = {20'd0, cfg_q.pulse_min};
      ssc_pkg::REG_PULSE_MAX:   prdata = {20'd0, cfg_q.pulse_max};
      ssc_pkg::REG_GRIPPER:     prdata = {24'd0, cfg_q.gripper_limit};
      default: prdata = '0;
    endcase
  end

  // Controller.
  ssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  ssc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_i         (cfg_q),
    .kind_i        (kind_i),
    .rx_byte_i     (rx_byte_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .channel_o     (channel_o),
    .pulse_us_o    (pulse_us_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

[hw/rtl/ssc_datapath.sv]
// Datapath: line parser, angle stores, ramp stepping, pulse mapping and output register.
`default_nettype none
`include "assert_macros.svh"
module ssc_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ssc_pkg::cmd_t       cmd_i,
  output ssc_pkg::status_t    status_o,
  input  ssc_pkg::cfg_t       cfg_i,
  input  wire                 kind_i,
  input  wire  [7:0]          rx_byte_i,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output logic                result_kind_o,
  output logic [2:0]          channel_o,
  output logic [11:0]         pulse_us_o,
  output logic                last_o
);

  localparam int CH_W  = ssc_pkg::CH_W;
  localparam int FC_W  = ssc_pkg::FC_W;
  localparam int LEN_W = ssc_pkg::LEN_W;
  localparam int AW    = ssc_pkg::ANGLE_W;
  localparam int VW    = ssc_pkg::VAL_W;
  localparam int NCH   = ssc_pkg::CHANNELS;

  // Parser state.
  logic [VW-1:0]     val_q, val_d;
  ssc_pkg::phase_e   phase_q, phase_d;
  logic              neg_q, neg_d;
  logic              nonempty_q, nonempty_d;
  logic [FC_W-1:0]   fc_q, fc_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              disc_q, disc_d;
  logic [7:0]        tick_q, tick_d;

  // Angle stores.
  logic [AW-1:0] cur_q [NCH];
  logic [AW-1:0] tgt_q [NCH];
  logic [AW-1:0] tgt_d [NCH];
  logic [AW-1:0] pend_q [NCH];

  // Ramp datapath registers.
  logic [CH_W-1:0]    ch_q;
  logic [AW-1:0]      angle_q;
  logic signed [21:0] prod_q;
  logic [11:0]        quo_q;
  logic               sign_q;

  // Output register.
  logic        out_valid_q;
  logic        out_kind_q;
  logic [2:0]  out_ch_q;
  logic [11:0] out_pulse_q;
  logic        out_last_q;

  logic byte_acc, tick_acc, is_nl, is_ws, is_dig, is_sign, is_comma;
  logic fin_write, pend_we, ack, load_ack, out_free;
  logic [AW-1:0]   grip_lim, lim_fc, fin_val;
  logic [VW-1:0]   raw_val;
  logic [13:0]     acc_val;
  logic [FC_W-1:0] fc_new;
  logic [8:0]      tick_next;
  logic            ramp_due;

  // Character classes and the gripper limit capped at the full range.
  assign is_nl    = (rx_byte_i == ssc_pkg::CHAR_NL);
  assign is_comma = (rx_byte_i == ssc_pkg::CHAR_COMMA);
  assign is_sign  = (rx_byte_i == ssc_pkg::CHAR_PLUS) || (rx_byte_i == ssc_pkg::CHAR_MINUS);
  assign is_dig   = (rx_byte_i >= ssc_pkg::CHAR_ZERO) && (rx_byte_i <= ssc_pkg::CHAR_NINE);
  assign is_ws    = (rx_byte_i == ssc_pkg::CHAR_SPACE) || (rx_byte_i == ssc_pkg::CHAR_TAB) ||
                    (rx_byte_i == ssc_pkg::CHAR_VT) || (rx_byte_i == ssc_pkg::CHAR_FF) ||
                    (rx_byte_i == ssc_pkg::CHAR_CR);
  assign grip_lim = (cfg_i.gripper_limit > ssc_pkg::ANGLE_MAX) ? ssc_pkg::ANGLE_MAX
                                                               : cfg_i.gripper_limit;
  assign byte_acc = cmd_i.accept && (kind_i == ssc_pkg::KIND_BYTE);
  assign tick_acc = cmd_i.accept && (kind_i == ssc_pkg::KIND_TICK);

  // Closing a field: clamp its value to the channel limit.
  assign fin_write = nonempty_q && (fc_q < FC_W'(NCH));
  assign lim_fc    = (fc_q == FC_W'(NCH - 1)) ? grip_lim : ssc_pkg::ANGLE_MAX;
  assign raw_val   = neg_q ? '0 : val_q;
  assign fin_val   = (raw_val > {{(VW-AW){1'b0}}, lim_fc}) ? lim_fc : raw_val[AW-1:0];
  assign fc_new    = fc_q + FC_W'(fin_write);
  assign acc_val   = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0}
                   + {6'd0, rx_byte_i - ssc_pkg::CHAR_ZERO};

  // Tick counting.
  assign tick_next = {1'b0, tick_q} + 9'd1;
  assign ramp_due  = (tick_next >= {1'b0, cfg_i.ramp_period});

  // Next parser state and line commit.
  always_comb begin
    val_d      = val_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    nonempty_d = nonempty_q;
    fc_d       = fc_q;
    len_d      = len_q;
    disc_d     = disc_q;
    pend_we    = 1'b0;
    ack        = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      tgt_d[i] = tgt_q[i];
    end
    if (byte_acc) begin
      if (is_nl) begin
        if (!disc_q) begin
          pend_we = fin_write;
          for (int i = 0; i < NCH; i++) begin
            if (FC_W'(i) < fc_new) begin
              tgt_d[i] = (fin_write && (fc_q == FC_W'(i))) ? fin_val : pend_q[i];
            end
          end
          ack = (fc_new == FC_W'(NCH));
        end
        val_d = '0; phase_d = ssc_pkg::PH_SKIP; neg_d = 1'b0; nonempty_d = 1'b0;
        fc_d = '0; len_d = '0; disc_d = 1'b0;
      end else if (!disc_q) begin
        if (len_q >= LEN_W'(ssc_pkg::LINE_LIMIT)) begin
          val_d = '0; phase_d = ssc_pkg::PH_SKIP; neg_d = 1'b0; nonempty_d = 1'b0;
          fc_d = '0; len_d = '0; disc_d = 1'b1;
        end else begin
          len_d = len_q + LEN_W'(1);
          if (is_comma) begin
            pend_we = fin_write;
            fc_d    = fc_new;
            val_d = '0; phase_d = ssc_pkg::PH_SKIP; neg_d = 1'b0; nonempty_d = 1'b0;
          end else begin
            nonempty_d = 1'b1;
            if ((phase_q == ssc_pkg::PH_SKIP) && is_ws) begin
              phase_d = phase_q;
            end else if ((phase_q == ssc_pkg::PH_SKIP) && is_sign) begin
              neg_d   = (rx_byte_i == ssc_pkg::CHAR_MINUS);
              phase_d = ssc_pkg::PH_SIGN;
            end else if ((phase_q != ssc_pkg::PH_DONE) && is_dig) begin
              phase_d = ssc_pkg::PH_DIGITS;
              val_d   = (acc_val > {4'd0, ssc_pkg::FIELD_SAT}) ? ssc_pkg::FIELD_SAT
                                                             : acc_val[VW-1:0];
            end else begin
              phase_d = ssc_pkg::PH_DONE;
            end
          end
        end
      end
    end
  end

  // Tick counter next value.
  always_comb begin
    tick_d = tick_q;
    if (tick_acc) begin
      tick_d = ramp_due ? 8'd0 : tick_next[7:0];
    end
  end

  // Parser and line registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q      <= '0;
      phase_q    <= ssc_pkg::PH_SKIP;
      neg_q      <= 1'b0;
      nonempty_q <= 1'b0;
      fc_q       <= '0;
      len_q      <= '0;
      disc_q     <= 1'b0;
      tick_q     <= '0;
    end else begin
      val_q      <= val_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      nonempty_q <= nonempty_d;
      fc_q       <= fc_d;
      len_q      <= len_d;
      disc_q     <= disc_d;
      tick_q     <= tick_d;
    end
  end

  // Pending angles of the line being received; only read after being written.
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q[fc_q[CH_W-1:0]] <= fin_val;
    end
  end

  // Ramp step of the selected channel.
  logic [AW-1:0] lim_ch, tgt_sel, cur_sel, t_eff, diff, new_angle;
  logic          up;
  assign lim_ch    = (ch_q == CH_W'(NCH - 1)) ? grip_lim : ssc_pkg::ANGLE_MAX;
  assign tgt_sel   = tgt_q[ch_q];
  assign cur_sel   = cur_q[ch_q];
  assign t_eff     = (tgt_sel > lim_ch) ? lim_ch : tgt_sel;
  assign up        = (t_eff > cur_sel);
  assign diff      = up ? (t_eff - cur_sel) : (cur_sel - t_eff);
  assign new_angle = (diff > {4'd0, cfg_i.step_size})
                   ? (up ? (cur_sel + {4'd0, cfg_i.step_size})
                         : (cur_sel - {4'd0, cfg_i.step_size}))
                   : t_eff;

  // Target and current angle stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        tgt_q[i] <= (i == NCH - 1) ? '0 : ssc_pkg::ANGLE_MID;
        cur_q[i] <= (i == NCH - 1) ? '0 : ssc_pkg::ANGLE_MID;
      end
    end else begin
      for (int i = 0; i < NCH; i++) begin
        tgt_q[i] <= tgt_d[i];
      end
      if (cmd_i.step) begin
        cur_q[ch_q] <= new_angle;
      end
    end
  end

  // Channel counter of the ramp update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (tick_acc) begin
      ch_q <= '0;
    end else if (cmd_i.emit) begin
      ch_q <= ch_q + CH_W'(1);
    end
  end

  // Pulse mapping: multiply, divide by 180, then offset.
  logic signed [12:0] span;
  logic [21:0]        mag;
  logic [40:0]        quo_full;
  assign span     = $signed({1'b0, cfg_i.pulse_max}) - $signed({1'b0, cfg_i.pulse_min});
  assign mag      = prod_q[21] ? (22'd0 - prod_q) : prod_q;
  assign quo_full = mag[19:0] * ssc_pkg::DIV_RECIP;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      angle_q <= new_angle;
    end
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, angle_q}) * span;
    end
    if (cmd_i.div) begin
      quo_q  <= quo_full[ssc_pkg::DIV_SHIFT +: 12];
      sign_q <= prod_q[21];
    end
  end

  // Output register, freed when the receiver takes the result.
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_ack = ack;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ack || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ack) begin
      out_kind_q  <= ssc_pkg::RES_ACK;
      out_ch_q    <= '0;
      out_pulse_q <= '0;
      out_last_q  <= 1'b1;
    end else if (cmd_i.emit) begin
      out_kind_q  <= ssc_pkg::RES_PULSE;
      out_ch_q    <= 3'(ch_q);
      out_pulse_q <= (sign_q ? (12'd0 - quo_q) : quo_q) + cfg_i.pulse_min;
      out_last_q  <= (ch_q == CH_W'(NCH - 1));
    end
  end

  assign status_o.out_free = out_free;
  assign status_o.ramp_due = ramp_due;
  assign status_o.last_ch  = (ch_q == CH_W'(NCH - 1));

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign channel_o     = out_ch_q;
  assign pulse_us_o    = out_pulse_q;
  assign last_o        = out_last_q;

  // An acknowledge is always the last result of its request.
  `SSC_ASSERT(a_ack_is_last, clk_i, rst_ni, (out_valid_q && out_kind_q) |-> out_last_q)
  // The field count never passes the number of channels.
  `SSC_ASSERT(a_fc_bound, clk_i, rst_ni, fc_q <= FC_W'(NCH))
  // A request is never taken while a ramp result is being loaded.
  `SSC_ASSERT_NEVER(a_no_accept_emit, clk_i, rst_ni, cmd_i.accept && cmd_i.emit)

endmodule
`default_nettype wire

[hw/rtl/ssc_ctrl.sv]
// Controller: sequences request acceptance and the per-channel ramp update.
`default_nettype none
`include "assert_macros.svh"
module ssc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 kind_i,
  output logic                in_stall_o,
  input  ssc_pkg::status_t    status_i,
  output ssc_pkg::cmd_t       cmd_o
);

  ssc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssc_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.out_free && (kind_i == ssc_pkg::KIND_TICK) &&
            status_i.ramp_due) begin
          state_d = ssc_pkg::ST_STEP;
        end
      end
      ssc_pkg::ST_STEP: state_d = ssc_pkg::ST_MUL;
      ssc_pkg::ST_MUL:  state_d = ssc_pkg::ST_DIV;
      ssc_pkg::ST_DIV:  state_d = ssc_pkg::ST_EMIT;
      ssc_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last_ch ? ssc_pkg::ST_IDLE : ssc_pkg::ST_STEP;
        end
      end
      default: state_d = ssc_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ssc_pkg::ST_IDLE: begin
        in_stall_o   = !status_i.out_free;
        cmd_o.accept = in_valid_i && status_i.out_free;
      end
      ssc_pkg::ST_STEP: cmd_o.step = 1'b1;
      ssc_pkg::ST_MUL:  cmd_o.mul  = 1'b1;
      ssc_pkg::ST_DIV:  cmd_o.div  = 1'b1;
      ssc_pkg::ST_EMIT: cmd_o.emit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  // A tick that is due starts the ramp walk.
  `SSC_ASSERT(a_ramp_start, clk_i, rst_ni,
    (cmd_o.accept && (kind_i == ssc_pkg::KIND_TICK) && status_i.ramp_due) |=>
    (state_q == ssc_pkg::ST_STEP))
  // Emitting the last channel ends the walk.
  `SSC_ASSERT(a_ramp_end, clk_i, rst_ni,
    (cmd_o.emit && status_i.last_ch) |=> (state_q == ssc_pkg::ST_IDLE))

endmodule
`default_nettype wire
